@@ hw/rtl/linear_layer_matmul_bias_defines.svh @@
// Assertion macros for the fully connected layer block.
`ifndef LINEAR_LAYER_MATMUL_BIAS_DEFINES_SVH
`define LINEAR_LAYER_MATMUL_BIAS_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle.
`define LLMB_ASSERT_SAME(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define LLMB_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`else

`define LLMB_ASSERT_SAME(name, clk, rst, pre, post)
`define LLMB_ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

@@ hw/rtl/llmb_pkg.sv @@
// Shared types and constants of the fully connected layer block.
package llmb_pkg;

   // Fraction bits of the Q4.12 format
   localparam int FRAC_BITS = 12;

   // Fixed port widths
   localparam int KIND_W   = 2;
   localparam int ROW_W    = 6;
   localparam int COL_W    = 6;
   localparam int OUT_ROW_W = 4;
   localparam int OUT_COL_W = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 7;
   localparam int BATCH_REG_W = 5;
   localparam int FEAT_REG_W  = 7;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD_INPUT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_WEIGHT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOAD_BIAS   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_COMPUTE     = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_ROWS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_FEATURES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_FEATURES = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIAS,
      ST_MAC,
      ST_DRAIN,
      ST_OUT
   } state_type;

endpackage

@@ hw/rtl/linear_layer_matmul_bias.sv @@
// Fully connected layer: matrix product of one batch row with the weights, plus bias.
//
// Usage:
//  - Request channel (req_*): one beat per item. Kinds load an input element,
//    a weight element or a bias into on-chip stores, or start the computation
//    of one batch row. Loads outside the configured sizes are dropped.
//  - Response channel (rsp_*): a compute beat yields out_features beats, one per
//    output feature in order, the final one with rsp_last set.
//  - csr_*: write batch_rows, in_features and out_features while idle.
// Operation: one shared multiply-accumulate unit reads one input and one weight per
// cycle from the two single-port stores, which have registered reads. Each output
// feature is worked as a bias read, in_features reads, a pipeline drain and a
// response cycle; a compute item works the output features in order.
// req_stall stays high while a row is in progress; one item is worked at a time.
// A stalled response holds its payload and pauses the row until it is taken.
// Reset (synchronous) returns the sequencer to idle and sets all three size
// registers to 1; store contents are undefined until written.
`include "linear_layer_matmul_bias_defines.svh"

module linear_layer_matmul_bias
   import llmb_pkg::*;
#(
   parameter int MAX_BATCH  = 16,
   parameter int MAX_IN     = 64,
   parameter int MAX_OUT    = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [KIND_W-1:0]            req_kind,
   input  logic [ROW_W-1:0]             req_row_index,
   input  logic [COL_W-1:0]             req_col_index,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [OUT_ROW_W-1:0]         rsp_out_row,
   output logic [OUT_COL_W-1:0]         rsp_out_col,
   output logic signed [DATA_WIDTH-1:0] rsp_out_value,
   output logic                         rsp_saturated,
   output logic                         rsp_last,
   // configuration port
   input  logic                         csr_write,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DAT_W-1:0]         csr_data
);

   // Store geometry: bias j sits in the extra slot at the end of weight row j
   localparam int IN_DEPTH = MAX_BATCH * MAX_IN;
   localparam int WROW     = MAX_IN + 1;
   localparam int W_DEPTH  = MAX_OUT * WROW;
   localparam int IA_W     = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
   localparam int WA_W     = $clog2(W_DEPTH);
   localparam int KW       = $clog2(MAX_IN + 1);
   localparam int JW       = $clog2(MAX_OUT + 1);
   localparam int BW       = $clog2(MAX_BATCH + 1);
   localparam int PROD_W   = 2 * DATA_WIDTH;
   localparam int ACC_W    = PROD_W + FRAC_BITS + KW + 1;

   localparam logic signed [ACC_W-1:0] SAT_MAX =
      {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN =
      {{(ACC_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // Stores
   logic [DATA_WIDTH-1:0] input_mem  [IN_DEPTH];
   logic [DATA_WIDTH-1:0] weight_mem [W_DEPTH];

   // Configuration registers
   logic [BATCH_REG_W-1:0] batch_rows_ff;
   logic [FEAT_REG_W-1:0]  in_features_ff;
   logic [FEAT_REG_W-1:0]  out_features_ff;

   // Sequencer
   state_type      state_ff, state_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [JW-1:0]  j_ff, j_in;
   logic [WA_W-1:0] w_base_ff, w_base_in;
   logic [IA_W-1:0] in_base_ff, in_base_in;
   logic [OUT_ROW_W-1:0] row_ff, row_in;

   // Read pipeline
   logic rd_bias_ff, rd_mac_ff, prod_vld_ff;
   logic [DATA_WIDTH-1:0] in_q_ff, w_q_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // Response registers
   logic [OUT_COL_W-1:0]         out_col_ff;
   logic [OUT_ROW_W-1:0]         out_row_ff;
   logic signed [DATA_WIDTH-1:0] out_value_ff;
   logic                         out_sat_ff;
   logic                         out_last_ff;

   // Combinational control
   logic [BW-1:0] nb;
   logic [KW-1:0] ni;
   logic [JW-1:0] no;
   logic req_fire, rsp_fire;
   logic row_in_batch, row_in_out, col_in_feat, col_in_out;
   logic k_last, j_last, pipe_busy, start_row, load_rsp;
   logic in_we, in_rd, w_we, w_rd, iss_bias, iss_mac;
   logic [IA_W-1:0] in_addr;
   logic [WA_W-1:0] w_addr;
   logic signed [ACC_W-1:0] acc_q;
   logic sat_hi, sat_lo;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   // Limit register values to the store sizes
   always_comb begin
      nb = (32'(batch_rows_ff) > 32'(MAX_BATCH)) ? BW'(MAX_BATCH) : BW'(batch_rows_ff);
      ni = (32'(in_features_ff) > 32'(MAX_IN)) ? KW'(MAX_IN) : KW'(in_features_ff);
      no = (32'(out_features_ff) > 32'(MAX_OUT)) ? JW'(MAX_OUT) : JW'(out_features_ff);
   end

   assign row_in_batch = 32'(req_row_index) < 32'(nb);
   assign row_in_out   = 32'(req_row_index) < 32'(no);
   assign col_in_feat  = 32'(req_col_index) < 32'(ni);
   assign col_in_out   = 32'(req_col_index) < 32'(no);
   assign k_last       = (32'(k_ff) + 32'd1) == 32'(ni);
   assign j_last       = (32'(j_ff) + 32'd1) == 32'(no);
   assign pipe_busy    = rd_bias_ff || rd_mac_ff || prod_vld_ff;
   assign start_row    = req_fire && (req_kind == KIND_COMPUTE) && row_in_batch &&
                         (no != '0);
   assign load_rsp     = (state_ff == ST_DRAIN) && !pipe_busy;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         batch_rows_ff   <= BATCH_REG_W'(1);
         in_features_ff  <= FEAT_REG_W'(1);
         out_features_ff <= FEAT_REG_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            CSR_BATCH_ROWS:   batch_rows_ff   <= csr_data[BATCH_REG_W-1:0];
            CSR_IN_FEATURES:  in_features_ff  <= csr_data[FEAT_REG_W-1:0];
            CSR_OUT_FEATURES: out_features_ff <= csr_data[FEAT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_row) state_in = ST_BIAS;
         end
         ST_BIAS: begin
            state_in = (ni == '0) ? ST_DRAIN : ST_MAC;
         end
         ST_MAC: begin
            if (k_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!pipe_busy) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_fire) state_in = j_last ? ST_IDLE : ST_BIAS;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and store access
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      in_we     = 1'b0;
      in_rd     = 1'b0;
      w_we      = 1'b0;
      w_rd      = 1'b0;
      iss_bias  = 1'b0;
      iss_mac   = 1'b0;
      in_addr   = in_base_ff + IA_W'(k_ff);
      w_addr    = w_base_ff + WA_W'(k_ff);
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_fire) begin
               case (req_kind)
                  KIND_LOAD_INPUT: begin
                     in_we   = row_in_batch && col_in_feat;
                     in_addr = IA_W'(req_row_index) * IA_W'(MAX_IN) + IA_W'(req_col_index);
                  end
                  KIND_LOAD_WEIGHT: begin
                     w_we   = row_in_out && col_in_feat;
                     w_addr = WA_W'(req_row_index) * WA_W'(WROW) + WA_W'(req_col_index);
                  end
                  KIND_LOAD_BIAS: begin
                     w_we   = col_in_out;
                     w_addr = WA_W'(req_col_index) * WA_W'(WROW) + WA_W'(MAX_IN);
                  end
                  default: ;
               endcase
            end
         end
         ST_BIAS: begin
            w_rd     = 1'b1;
            w_addr   = w_base_ff + WA_W'(MAX_IN);
            iss_bias = 1'b1;
         end
         ST_MAC: begin
            in_rd   = 1'b1;
            w_rd    = 1'b1;
            iss_mac = 1'b1;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
         end
         default: ;
      endcase
   end

   // Counter and base address updates
   always_comb begin
      k_in       = k_ff;
      j_in       = j_ff;
      w_base_in  = w_base_ff;
      in_base_in = in_base_ff;
      row_in     = row_ff;
      if (state_ff == ST_IDLE && start_row) begin
         j_in       = '0;
         w_base_in  = '0;
         in_base_in = IA_W'(req_row_index) * IA_W'(MAX_IN);
         row_in     = req_row_index[OUT_ROW_W-1:0];
      end
      if (state_ff == ST_BIAS) k_in = '0;
      if (state_ff == ST_MAC)  k_in = k_ff + KW'(1);
      if (state_ff == ST_OUT && rsp_fire) begin
         j_in      = j_ff + JW'(1);
         w_base_in = w_base_ff + WA_W'(WROW);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_bias_ff  <= 1'b0;
         rd_mac_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_bias_ff  <= iss_bias;
         rd_mac_ff   <= iss_mac;
         prod_vld_ff <= rd_mac_ff;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      j_ff       <= j_in;
      w_base_ff  <= w_base_in;
      in_base_ff <= in_base_in;
      row_ff     <= row_in;
   end

   // Input store: one port, registered read
   always_ff @(posedge clock) begin
      if (in_we) input_mem[in_addr] <= req_value;
      if (in_rd) in_q_ff <= input_mem[in_addr];
   end

   // Weight and bias store: one port, registered read
   always_ff @(posedge clock) begin
      if (w_we) weight_mem[w_addr] <= req_value;
      if (w_rd) w_q_ff <= weight_mem[w_addr];
   end

   // Multiply, then accumulate; the bias read seeds the accumulator
   always_ff @(posedge clock) begin
      if (rd_mac_ff) prod_ff <= $signed(in_q_ff) * $signed(w_q_ff);
      if (rd_bias_ff) begin
         acc_ff <= {{(ACC_W-DATA_WIDTH){w_q_ff[DATA_WIDTH-1]}}, w_q_ff} <<< FRAC_BITS;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   // Floor shift and saturate
   assign acc_q  = acc_ff >>> FRAC_BITS;
   assign sat_hi = acc_q > SAT_MAX;
   assign sat_lo = acc_q < SAT_MIN;

   // Capture the response once the pipeline is empty; hold it while stalled
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         out_row_ff   <= row_ff;
         out_col_ff   <= OUT_COL_W'(j_ff);
         out_value_ff <= sat_hi ? OUT_MAX : (sat_lo ? OUT_MIN : acc_q[DATA_WIDTH-1:0]);
         out_sat_ff   <= sat_hi || sat_lo;
         out_last_ff  <= j_last;
      end
   end

   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_saturated = out_sat_ff;
   assign rsp_last      = out_last_ff;

   // Checks
   `LLMB_ASSERT_SAME(a_no_rsp_when_open, clock, reset, !req_stall, !rsp_valid)
   `LLMB_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_fire && rsp_last, !req_stall)
   `LLMB_ASSERT_SAME(a_pipe_empty_idle, clock, reset, state_ff == ST_IDLE, !pipe_busy)
   `LLMB_ASSERT_NEXT(a_start_issues_bias, clock, reset, start_row, iss_bias)

endmodule

@@ tb/tb_linear_layer_matmul_bias.sv @@
// Testbench for the fully connected layer block: directed beats, then random loads and rows.
module tb_linear_layer_matmul_bias;
   import llmb_pkg::*;

   localparam int MAX_BATCH = 16;
   localparam int MAX_IN = 64;
   localparam int MAX_OUT = 64;
   localparam int DW = 16;
   localparam longint SAT_MAX = 2 ** (DW - 1) - 1;
   localparam longint SAT_MIN = -(2 ** (DW - 1));
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES = 80;
   localparam int IDLE_LIMIT = 3000;
   localparam int PRINT_LIMIT = 40;
   localparam int DIR_N = 25;
   localparam int PHASE_N = 11;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [ROW_W-1:0]     row;
      logic [COL_W-1:0]     col;
      logic signed [DW-1:0] value;
   } req_beat_t;

   typedef struct packed {
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_COL_W-1:0] col;
      logic signed [DW-1:0] value;
      logic                 sat;
      logic                 last;
   } fc_result_t;

   // One directed beat, with its result typed in where it is obvious
   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [ROW_W-1:0]     row;
      logic [COL_W-1:0]     col;
      logic signed [DW-1:0] value;
      logic                 typed;
      logic                 has_result;
      logic signed [DW-1:0] want_value;
      logic                 want_sat;
   } dir_step_t;

   typedef struct {
      int batch;
      int in_f;
      int out_f;
      int beats;
      bit calm;
      bit hold;
   } phase_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [KIND_W-1:0]    req_kind = '0;
   logic [ROW_W-1:0]     req_row_index = '0;
   logic [COL_W-1:0]     req_col_index = '0;
   logic signed [DW-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [OUT_ROW_W-1:0] rsp_out_row;
   logic [OUT_COL_W-1:0] rsp_out_col;
   logic signed [DW-1:0] rsp_out_value;
   logic                 rsp_saturated;
   logic                 rsp_last;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   // Predictor state: stores, written flags and size registers
   logic signed [DW-1:0]   in_mem [MAX_BATCH*MAX_IN];
   logic signed [DW-1:0]   w_mem [MAX_OUT*MAX_IN];
   logic signed [DW-1:0]   b_mem [MAX_OUT];
   bit                     in_set [MAX_BATCH*MAX_IN];
   bit                     w_set [MAX_OUT*MAX_IN];
   bit                     b_set [MAX_OUT];
   logic [BATCH_REG_W-1:0] cfg_batch = 1;
   logic [FEAT_REG_W-1:0]  cfg_in = 1;
   logic [FEAT_REG_W-1:0]  cfg_out = 1;

   fc_result_t pending_outputs [$];
   int         errors = 0;
   int         idle_cycles = 0;
   bit         calm = 1'b0;
   bit         hold_req = 1'b0;

   linear_layer_matmul_bias dut (.*);

   always #5 clock = ~clock;

   // Sizes in use: each register limited to its store dimension
   function automatic int used_batch();
      return (cfg_batch > MAX_BATCH) ? MAX_BATCH : cfg_batch;
   endfunction

   function automatic int used_in();
      return (cfg_in > MAX_IN) ? MAX_IN : cfg_in;
   endfunction

   function automatic int used_out();
      return (cfg_out > MAX_OUT) ? MAX_OUT : cfg_out;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 88) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_below(int n);
      return (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
   endfunction

   // Apply one accepted beat: write the stores, or work out the row's results
   function automatic void fc_predict_beat(req_beat_t it, logic push);
      int         nb, ni, no, r, c, j, k;
      longint     acc;
      fc_result_t res;
      nb = used_batch();
      ni = used_in();
      no = used_out();
      r = it.row;
      c = it.col;
      case (it.kind)
         KIND_LOAD_INPUT: begin
            if (r < nb && c < ni) begin
               in_mem[r*MAX_IN + c] = it.value;
               in_set[r*MAX_IN + c] = 1'b1;
            end
         end
         KIND_LOAD_WEIGHT: begin
            if (r < no && c < ni) begin
               w_mem[r*MAX_IN + c] = it.value;
               w_set[r*MAX_IN + c] = 1'b1;
            end
         end
         KIND_LOAD_BIAS: begin
            if (c < no) begin
               b_mem[c] = it.value;
               b_set[c] = 1'b1;
            end
         end
         default: begin
            if (push && r < nb) begin
               for (j = 0; j < no; j++) begin
                  // exact products, bias aligned to the product scale, floor shift
                  acc = 0;
                  for (k = 0; k < ni; k++)
                     acc += longint'(in_mem[r*MAX_IN + k]) * longint'(w_mem[j*MAX_IN + k]);
                  acc += longint'(b_mem[j]) <<< FRAC_BITS;
                  acc = acc >>> FRAC_BITS;
                  res.row = OUT_ROW_W'(r);
                  res.col = OUT_COL_W'(j);
                  res.last = (j == no - 1);
                  if (acc > SAT_MAX) begin
                     res.value = DW'(SAT_MAX);
                     res.sat = 1'b1;
                  end else if (acc < SAT_MIN) begin
                     res.value = DW'(SAT_MIN);
                     res.sat = 1'b1;
                  end else begin
                     res.value = DW'(acc);
                     res.sat = 1'b0;
                  end
                  pending_outputs.push_back(res);
               end
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
   endtask

   // Offer one request beat, hold it until taken, then update the predictor
   task automatic send_item(req_beat_t it, logic typed, logic has_result, fc_result_t want);
      int gap;
      @(negedge clock);
      req_kind = it.kind;
      req_row_index = it.row;
      req_col_index = it.col;
      req_value = it.value;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      fc_predict_beat(it, !typed);
      if (typed && has_result) pending_outputs.push_back(want);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Drop valid and wait until every pending result has come back
   task automatic drain_outputs();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int data);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = CSR_DAT_W'(data);
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_BATCH_ROWS:   cfg_batch = BATCH_REG_W'(data);
         CSR_IN_FEATURES:  cfg_in = FEAT_REG_W'(data);
         CSR_OUT_FEATURES: cfg_out = FEAT_REG_W'(data);
         default: ;
      endcase
   endtask

   // Load every operand of a row that was never written, so no undefined entry is read
   task automatic fill_row_operands(int r);
      int        ni, no, j, k;
      req_beat_t ld;
      ni = used_in();
      no = used_out();
      for (k = 0; k < ni; k++) begin
         if (!in_set[r*MAX_IN + k]) begin
            ld = '{KIND_LOAD_INPUT, ROW_W'(r), COL_W'(k), DW'($urandom)};
            send_item(ld, 1'b0, 1'b0, '0);
         end
      end
      for (j = 0; j < no; j++) begin
         if (!b_set[j]) begin
            ld = '{KIND_LOAD_BIAS, ROW_W'($urandom), COL_W'(j), DW'($urandom)};
            send_item(ld, 1'b0, 1'b0, '0);
         end
         for (k = 0; k < ni; k++) begin
            if (!w_set[j*MAX_IN + k]) begin
               ld = '{KIND_LOAD_WEIGHT, ROW_W'(j), COL_W'(k), DW'($urandom)};
               send_item(ld, 1'b0, 1'b0, '0);
            end
         end
      end
   endtask

   // Mix of row computes, in-range loads and raw noise beats
   function automatic req_beat_t rand_item();
      req_beat_t it;
      int        sel;
      sel = $urandom_range(0, 99);
      it.kind = KIND_W'($urandom);
      it.row = ROW_W'($urandom);
      it.col = COL_W'($urandom);
      it.value = DW'($urandom);
      if ($urandom_range(0, 7) == 0)
         it.value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      if (sel < 30) begin
         it.kind = KIND_COMPUTE;
         if ($urandom_range(0, 5) != 0) it.row = ROW_W'(pick_below(used_batch()));
      end else if (sel < 75) begin
         case ($urandom_range(0, 2))
            0: begin
               it.kind = KIND_LOAD_INPUT;
               it.row = ROW_W'(pick_below(used_batch()));
               it.col = COL_W'(pick_below(used_in()));
            end
            1: begin
               it.kind = KIND_LOAD_WEIGHT;
               it.row = ROW_W'(pick_below(used_out()));
               it.col = COL_W'(pick_below(used_in()));
            end
            default: begin
               it.kind = KIND_LOAD_BIAS;
               it.col = COL_W'(pick_below(used_out()));
            end
         endcase
      end
      return it;
   endfunction

   // Drive the response stall: random holds, a long hold on request, none while calm
   initial begin : rsp_side
      int run;
      run = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            run = HOLD_CYCLES;
         end else if (run == 0 && !calm && $urandom_range(0, 2) == 0) begin
            run = pick_gap();
         end
         rsp_stall = (run > 0);
         if (run > 0) run--;
      end
   end

   // Check each accepted result beat against the oldest expectation; count idle cycles
   always @(posedge clock) begin : check_outputs
      fc_result_t want;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (pending_outputs.size() == 0) begin
               report_mismatch("result beat with nothing pending, out_col", rsp_out_col, -1);
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_out_row !== want.row)
                  report_mismatch("out_row", rsp_out_row, want.row);
               if (rsp_out_col !== want.col)
                  report_mismatch("out_col", rsp_out_col, want.col);
               if (rsp_out_value !== want.value)
                  report_mismatch("out_value", rsp_out_value, want.value);
               if (rsp_saturated !== want.sat)
                  report_mismatch("saturated", rsp_saturated, want.sat);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      dir_step_t  steps [DIR_N];
      phase_t     phases [PHASE_N];
      phase_t     ph;
      req_beat_t  it;
      fc_result_t want;
      bit         held;
      int         b;
      // kind, row, col, value, typed, has_result, want_value, want_sat
      steps = '{
         '{KIND_LOAD_BIAS,   6'd63, 6'd0, 16'sh0000, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_LOAD_INPUT,  6'd0,  6'd0, 16'sh7FFF, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_LOAD_WEIGHT, 6'd0,  6'd0, 16'sh7FFF, 1'b1, 1'b0, 16'sh0000, 1'b0},
         // value field of a compute beat is unused
         '{KIND_COMPUTE,     6'd0,  6'd0, 16'shFFFF, 1'b1, 1'b1, 16'sh7FFF, 1'b1},
         '{KIND_LOAD_INPUT,  6'd0,  6'd0, 16'sh8000, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_LOAD_WEIGHT, 6'd0,  6'd0, 16'sh8000, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_COMPUTE,     6'd0,  6'd0, 16'sh0000, 1'b1, 1'b1, 16'sh7FFF, 1'b1},
         '{KIND_LOAD_WEIGHT, 6'd0,  6'd0, 16'sh7FFF, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_COMPUTE,     6'd0,  6'd0, 16'sh0000, 1'b1, 1'b1, 16'sh8000, 1'b1},
         '{KIND_LOAD_INPUT,  6'd0,  6'd0, 16'sh0001, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_LOAD_WEIGHT, 6'd0,  6'd0, 16'shFFFF, 1'b1, 1'b0, 16'sh0000, 1'b0},
         // tiny negative sum floors to -1
         '{KIND_COMPUTE,     6'd0,  6'd0, 16'sh0000, 1'b1, 1'b1, 16'shFFFF, 1'b0},
         '{KIND_LOAD_BIAS,   6'd5,  6'd0, 16'sh8000, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_COMPUTE,     6'd0,  6'd0, 16'sh0000, 1'b1, 1'b1, 16'sh8000, 1'b1},
         '{KIND_LOAD_WEIGHT, 6'd0,  6'd0, 16'sh0001, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_COMPUTE,     6'd0,  6'd0, 16'sh0000, 1'b1, 1'b1, 16'sh8000, 1'b0},
         '{KIND_LOAD_BIAS,   6'd0,  6'd0, 16'sh7FFF, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_COMPUTE,     6'd0,  6'd0, 16'sh0000, 1'b1, 1'b1, 16'sh7FFF, 1'b0},
         // loads outside the sizes in use are dropped
         '{KIND_LOAD_INPUT,  6'd1,  6'd0, 16'sh5555, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_LOAD_INPUT,  6'd0,  6'd1, 16'sh5555, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_LOAD_WEIGHT, 6'd1,  6'd0, 16'sh5555, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_LOAD_BIAS,   6'd0,  6'd1, 16'sh5555, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_COMPUTE,     6'd0,  6'd0, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 1'b0},
         // compute rows beyond the batch give nothing
         '{KIND_COMPUTE,     6'd1,  6'd0, 16'sh0000, 1'b1, 1'b0, 16'sh0000, 1'b0},
         '{KIND_COMPUTE,     6'd63, 6'd63, 16'shAAAA, 1'b1, 1'b0, 16'sh0000, 1'b0}
      };
      // batch, in, out, beats, calm, hold; a negative batch picks random sizes
      phases = '{
         '{4, 4, 3, 20, 1'b0, 1'b0},
         '{31, 2, 2, 16, 1'b0, 1'b0},
         '{16, 2, 2, 12, 1'b1, 1'b0},
         '{1, 64, 1, 14, 1'b0, 1'b0},
         '{1, 127, 1, 8, 1'b0, 1'b0},
         '{1, 1, 64, 10, 1'b0, 1'b1},
         '{2, 0, 127, 6, 1'b0, 1'b0},
         '{0, 3, 3, 10, 1'b0, 1'b0},
         '{99, 3, 4, 12, 1'b0, 1'b0},
         '{3, 5, 0, 10, 1'b0, 1'b0},
         '{-1, 0, 0, 20, 1'b0, 1'b0}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed beats at the reset sizes
      foreach (steps[i]) begin
         it = '{steps[i].kind, steps[i].row, steps[i].col, steps[i].value};
         want = '{it.row[OUT_ROW_W-1:0], 6'd0, steps[i].want_value, steps[i].want_sat, 1'b1};
         send_item(it, steps[i].typed, steps[i].has_result, want);
      end

      // Random beats under a series of size settings
      foreach (phases[p]) begin
         ph = phases[p];
         if (ph.batch < 0) begin
            ph.batch = $urandom_range(1, 6);
            ph.in_f = $urandom_range(1, 8);
            ph.out_f = $urandom_range(1, 6);
         end
         drain_outputs();
         repeat (SETTLE_CYCLES) @(negedge clock);
         write_csr(CSR_BATCH_ROWS, ph.batch);
         write_csr(CSR_IN_FEATURES, ph.in_f);
         write_csr(CSR_OUT_FEATURES, ph.out_f);
         calm = ph.calm;
         held = 1'b0;
         for (b = 0; b < ph.beats; b++) begin
            it = rand_item();
            if (ph.hold && b == 0) begin
               it.kind = KIND_COMPUTE;
               it.row = '0;
            end
            if (it.kind == KIND_COMPUTE && it.row < used_batch()) begin
               fill_row_operands(it.row);
               // hold off the receiver while the sender keeps offering beats
               if (ph.hold && !held) begin
                  hold_req = 1'b1;
                  held = 1'b1;
               end
            end
            send_item(it, 1'b0, 1'b0, '0);
            if ($urandom_range(0, 24) == 0) drain_outputs();
         end
      end

      calm = 1'b0;
      drain_outputs();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/llmb_pkg.sv
hw/rtl/linear_layer_matmul_bias.sv
tb/tb_linear_layer_matmul_bias.sv
